// ===== design/elwq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package elwq_pkg;

    // Field widths of the echo input and the level output
    localparam int ECHO_W  = 13;
    localparam int LEVEL_W = 7;

    // Queue status seen by both sides of the queue
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== design/echo_level_window_quantizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: with the back end free, an accepted sample is queued, popped in S_IDLE and passed
// through S_CHECK, S_DIV (skipped for an empty or saturated window), S_QUANT and S_EMIT,
// which loads the output register only for a changed level. Flow: the back end works on
// one sample at a time in its 7-step restoring divide; the front end queues two more meanwhile.
// Reset: synchronous, active low; clears the sample window, running sum, queue and
// stored level at once, so samples are accepted from the first cycle after reset.

module echo_level_window_quantizer #(
    parameter int WINDOW_LEN = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [elwq_pkg::ECHO_W-1:0]  i_echo_time_us,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [elwq_pkg::LEVEL_W-1:0]      o_level_percent
);
    import elwq_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = ECHO_W + CNT_W;
    localparam int DATA_W = SUM_W + CNT_W;

    t_q_stat           w_q_stat;
    logic              w_push;
    logic              w_pop;
    logic [SUM_W-1:0]  w_f_sum;
    logic [CNT_W-1:0]  w_f_cnt;
    logic [SUM_W-1:0]  w_b_sum;
    logic [CNT_W-1:0]  w_b_cnt;
    logic [DATA_W-1:0] w_q_out;

    assign o_in_stall       = w_q_stat.full;
    assign {w_b_sum, w_b_cnt} = w_q_out;

    elwq_front #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_echo_time_us (i_echo_time_us),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_sum          (w_f_sum),
        .o_cnt          (w_f_cnt)
    );

    elwq_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_sum, w_f_cnt}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_q_stat)
    );

    elwq_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (w_q_stat),
        .i_sum           (w_b_sum),
        .i_cnt           (w_b_cnt),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .o_level_percent (o_level_percent),
        .i_out_stall     (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== design/elwq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module elwq_front #(
    parameter int WINDOW_LEN = 8,
    parameter int SUM_W      = 17,
    parameter int CNT_W      = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [elwq_pkg::ECHO_W-1:0] i_echo_time_us,
    input  wire elwq_pkg::t_q_stat           i_q_stat,
    output logic                             o_push,
    output logic [SUM_W-1:0]                 o_sum,
    output logic [CNT_W-1:0]                 o_cnt
);
    import elwq_pkg::*;

    logic [ECHO_W-1:0] r_win [WINDOW_LEN];
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_cnt;
    logic [ECHO_W-1:0] w_old;
    logic              w_accept;

    // Update the running sum and nonzero count as the oldest sample drops out
    always_comb begin
        w_accept = i_in_valid && !i_q_stat.full;
        w_old    = r_win[WINDOW_LEN-1];
        n_sum    = r_sum + SUM_W'(i_echo_time_us) - SUM_W'(w_old);
        n_cnt    = r_cnt + CNT_W'(i_echo_time_us != '0) - CNT_W'(w_old != '0);
    end

    assign o_push = w_accept;
    assign o_sum  = n_sum;
    assign o_cnt  = n_cnt;

    // Shift the window on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) r_win[i] <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (w_accept) begin
            for (int i = WINDOW_LEN - 1; i > 0; i--) r_win[i] <= r_win[i-1];
            r_win[0] <= i_echo_time_us;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== design/elwq_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module elwq_queue #(
    parameter int DATA_W = 21
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output elwq_pkg::t_q_stat      o_stat
);
    import elwq_pkg::*;

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_fill;

    assign o_data       = r_mem[r_rptr];
    assign o_stat.full  = (r_fill == 2'd2);
    assign o_stat.empty = (r_fill == 2'd0);

    // Hold the entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/elwq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module elwq_back #(
    parameter int SUM_W = 17,
    parameter int CNT_W = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire elwq_pkg::t_q_stat            i_q_stat,
    input  wire logic [SUM_W-1:0]             i_sum,
    input  wire logic [CNT_W-1:0]             i_cnt,
    output logic                              o_pop,
    output logic                              o_out_valid,
    output logic [elwq_pkg::LEVEL_W-1:0]      o_level_percent,
    input  wire logic                         i_out_stall
);
    import elwq_pkg::*;

    // Scale: 343 / 6000 per microsecond of averaged echo
    localparam int SCALE_NUM   = 343;
    localparam int SCALE_NUM_W = 9;
    localparam int SCALE_DEN   = 6000;
    localparam int SCALE_DEN_W = 13;
    localparam int FULL_LEVEL  = 100;
    localparam int QUOT_W      = 7;
    localparam int BIT_W       = $clog2(QUOT_W);
    localparam int NUM_W       = SUM_W + SCALE_NUM_W;
    localparam int DEN_W       = CNT_W + SCALE_DEN_W;
    localparam int CMP_W       = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;
    // Decimal digit split by reciprocal: raw * 205 >> 11 is raw / 10 below 1029
    localparam int RECIP_MUL   = 205;
    localparam int RECIP_SHIFT = 11;
    localparam int PROD_W      = LEVEL_W + 8;
    localparam int DIGIT_W     = PROD_W - RECIP_SHIFT;
    localparam int QUANT_STEP  = 10;
    localparam int UNITS_SPLIT = 5;
    localparam int OFS_HIGH    = 15;
    localparam int OFS_LOW     = 10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_QUANT,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [CMP_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic               r_zero;
    logic [CMP_W-1:0]   r_rem;
    logic [CMP_W-1:0]   r_dsh;
    logic [QUOT_W-1:0]  r_quot;
    logic [BIT_W-1:0]   r_bit;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_last;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;

    logic [NUM_W-1:0]   w_num;
    logic [DEN_W-1:0]   w_den;
    logic [CMP_W-1:0]   w_lim;
    logic [QUOT_W-1:0]  w_scaled;
    logic [LEVEL_W-1:0] w_raw;
    logic [PROD_W-1:0]  w_prod;
    logic [DIGIT_W-1:0] w_tens;
    logic [LEVEL_W-1:0] w_tens_x10;
    logic [DIGIT_W-1:0] w_units;
    logic [LEVEL_W-1:0] w_quant;
    logic               w_emit;

    assign o_pop           = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_out_valid     = r_out_valid;
    assign o_level_percent = r_out_level;

    // Load the output register when a changed level finds it free
    assign w_emit = (r_state == S_EMIT) && (r_level != r_last) &&
                    (!r_out_valid || !i_out_stall);

    // Scale the popped sum and count, and bound the quotient
    always_comb begin
        w_num = NUM_W'(i_sum) * NUM_W'(SCALE_NUM);
        w_den = DEN_W'(i_cnt) * DEN_W'(SCALE_DEN);
        w_lim = CMP_W'(r_den) << QUOT_W;
    end

    // Clamp, take the fill and quantize it to the reported steps
    always_comb begin
        w_scaled   = (r_quot > QUOT_W'(FULL_LEVEL)) ? QUOT_W'(FULL_LEVEL) : r_quot;
        w_raw      = LEVEL_W'(FULL_LEVEL) - LEVEL_W'(w_scaled);
        w_prod     = PROD_W'(w_raw) * PROD_W'(RECIP_MUL);
        w_tens     = w_prod[PROD_W-1:RECIP_SHIFT];
        w_tens_x10 = LEVEL_W'(w_tens) * LEVEL_W'(QUANT_STEP);
        w_units    = DIGIT_W'(w_raw - w_tens_x10);
        if (w_raw >= LEVEL_W'(FULL_LEVEL)) begin
            w_quant = '0;
        end else if (w_units > DIGIT_W'(UNITS_SPLIT)) begin
            w_quant = w_tens_x10 + LEVEL_W'(OFS_HIGH);
        end else begin
            w_quant = w_tens_x10 + LEVEL_W'(OFS_LOW);
        end
    end

    // Sequence divide, quantize and emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_num   <= CMP_W'(w_num);
                        r_den   <= w_den;
                        r_zero  <= (i_cnt == '0);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_rem  <= r_num;
                    r_dsh  <= CMP_W'(r_den) << (QUOT_W - 1);
                    r_bit  <= BIT_W'(QUOT_W - 1);
                    if (r_zero) begin
                        r_quot  <= '0;
                        r_state <= S_QUANT;
                    end else if (r_num >= w_lim) begin
                        r_quot  <= QUOT_W'(FULL_LEVEL);
                        r_state <= S_QUANT;
                    end else begin
                        r_quot  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem         <= r_rem - r_dsh;
                        r_quot[r_bit] <= 1'b1;
                    end
                    r_dsh <= r_dsh >> 1;
                    if (r_bit == '0) begin
                        r_state <= S_QUANT;
                    end else begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
                S_QUANT: begin
                    r_level <= w_quant;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_level == r_last) begin
                        r_state <= S_IDLE;
                    end else if (w_emit) begin
                        r_out_level <= r_level;
                        r_last      <= r_level;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import elwq_pkg::*;

    localparam int WINDOW      = 8;
    localparam int SOUND_NUM   = 343;    // 0.0343 cm/us, scaled by 10000
    localparam int SOUND_DEN   = 6000;   // round trip over 0.3 m full scale, same scale
    localparam int FULL_FILL   = 100;
    localparam int IDLE_LIMIT  = 2000;   // cycles with no transaction on either side
    localparam int SETTLE      = 40;     // cycles allowed after the last expected level
    localparam int MAX_REPORTS = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 o_in_stall;
    logic [ECHO_W-1:0]    in_echo;
    logic                 o_out_valid;
    logic                 out_stall;
    logic [LEVEL_W-1:0]   o_level_percent;

    echo_level_window_quantizer #(
        .WINDOW_LEN(WINDOW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_echo_time_us (in_echo),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_level_percent(o_level_percent)
    );

    // Own copy of the echo window and the stored level
    logic [ECHO_W-1:0]  echo_hist [WINDOW];
    logic [LEVEL_W-1:0] held_level;
    logic [LEVEL_W-1:0] level_q [$];

    int  mismatches;
    int  echoes_sent;
    int  levels_seen;
    int  idle_cycles;
    int  stall_left;
    bit  out_taken;
    bit  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 7) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Shift in one echo and queue the level it yields, if it changes
    task automatic predict_level(input logic [ECHO_W-1:0] echo);
        longint unsigned sum;
        longint unsigned cnt;
        longint unsigned scaled;
        int unsigned     raw;
        int unsigned     lvl;
        for (int i = WINDOW - 1; i > 0; i--)
            echo_hist[i] = echo_hist[i - 1];
        echo_hist[0] = echo;
        sum = 0;
        cnt = 0;
        foreach (echo_hist[i]) begin
            if (echo_hist[i] != '0) begin
                sum += echo_hist[i];
                cnt++;
            end
        end
        if (cnt == 0) begin
            raw = FULL_FILL;
        end else begin
            scaled = (sum * SOUND_NUM) / (SOUND_DEN * cnt);
            if (scaled > FULL_FILL)
                scaled = FULL_FILL;
            raw = FULL_FILL - int'(scaled);
        end
        if (raw >= FULL_FILL)
            lvl = 0;
        else if (raw % 10 > 5)
            lvl = (raw / 10 + 1) * 10 + 5;
        else
            lvl = (raw / 10) * 10 + 10;
        if (lvl[LEVEL_W-1:0] != held_level) begin
            held_level = lvl[LEVEL_W-1:0];
            level_q.push_back(held_level);
        end
    endtask

    // Send one echo transaction after a random gap; valid stays high on a zero gap
    task automatic send_echo(input logic [ECHO_W-1:0] echo);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_echo  <= echo;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_level(echo);
        echoes_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (level_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input int exp_v, input int act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d: %s, expected %0d, got %0d", mismatches, what,
                     exp_v, act_v);
    endtask

    // Pick an echo around a target, with the odd dropout or stray reading
    function automatic logic [ECHO_W-1:0] jittered_echo(input int base);
        int v;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return ECHO_W'($urandom_range(0, (1 << ECHO_W) - 1));
            default: begin
                v = base + $urandom_range(0, 40) - 20;
                if (v < 1)
                    v = 1;
                return ECHO_W'(v);
            end
        endcase
    endfunction

    // Extremes of the echo field, ending on a window of timeouts
    task automatic test_window_extremes();
        send_echo('0);
        send_echo('1);
        send_echo(ECHO_W'(1));
        send_echo(ECHO_W'(13'h1555));
        send_echo(ECHO_W'(13'h0AAA));
        send_echo(ECHO_W'(5830));
        repeat (WINDOW) send_echo('0);
    endtask

    // Full-scale saturation and the quantiser's units boundaries
    task automatic test_level_boundaries();
        send_echo(ECHO_W'(17));
        send_echo(ECHO_W'(30));
        send_echo(ECHO_W'(1750));
        send_echo(ECHO_W'(1720));
        send_echo(ECHO_W'(2000));
        send_echo(ECHO_W'(900));
        send_echo('1);
        send_echo('1);
    endtask

    // Runs of echoes settling on random levels, mixed with noise
    task automatic test_random_levels(input int count);
        int base;
        int run;
        int k;
        k = 0;
        while (k < count) begin
            run = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0:       base = 0;
                1:       base = $urandom_range(1800, (1 << ECHO_W) - 1);
                default: base = $urandom_range(1, 1800);
            endcase
            repeat (run) begin
                if (base == 0)
                    send_echo('0);
                else
                    send_echo(jittered_echo(base));
                k++;
            end
        end
    endtask

    // Drive with no gaps on either side
    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_levels(150);
        no_idle = 1'b0;
    endtask

    // Hold the sender until every queued level has come out
    task automatic test_pause_for_drain();
        repeat (6) begin
            test_random_levels(20);
            wait_drained();
        end
    endtask

    // Draw a stall length after each output transaction
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_taken  = 1'b0;
            stall_left = draw_wait();
        end
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Check each level transaction against the oldest expectation
    always @(posedge i_clk) begin
        logic [LEVEL_W-1:0] want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            out_taken = 1'b1;
            levels_seen++;
            if (level_q.size() == 0) begin
                note_mismatch("level with none expected", -1, int'(o_level_percent));
            end else begin
                want = level_q.pop_front();
                if (o_level_percent !== want)
                    note_mismatch("level_percent", int'(want), int'(o_level_percent));
            end
        end
    end

    // End the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_echo     = '0;
        out_stall   = 1'b0;
        mismatches  = 0;
        echoes_sent = 0;
        levels_seen = 0;
        idle_cycles = 0;
        stall_left  = 0;
        out_taken   = 1'b0;
        no_idle     = 1'b0;
        held_level  = '0;
        foreach (echo_hist[i])
            echo_hist[i] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_window_extremes();
        test_level_boundaries();
        test_random_levels(1600);
        test_back_to_back();
        test_pause_for_drain();
        wait_drained();

        if (level_q.size() != 0)
            note_mismatch("levels never delivered", level_q.size(), 0);
        $display("covered %0d echo samples and %0d level changes, %0d mismatches",
                 echoes_sent, levels_seen, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
